[sv/dnir_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the day/night IR-cut filter controller.
// No dependencies; every other file imports this package.
package dnir_pkg;

   localparam int unsigned AVG_COUNT = 8;
   localparam int unsigned CNT_W     = $clog2(AVG_COUNT + 1);
   localparam int unsigned SUM_W     = 12 + $clog2(AVG_COUNT);
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
   localparam logic [1:0]  EFFECT_BW    = 2'd2;
   localparam logic [1:0]  EFFECT_COLOR = 2'd0;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_READING = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NIGHT_THR  = 3'd0,
      CSR_DAY_THR    = 3'd1,
      CSR_INTERVAL   = 3'd2,
      CSR_PULSE_LEN  = 3'd3,
      CSR_FORCE_BW   = 3'd4,
      CSR_SENSOR     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [11:0] night_threshold;
      logic [11:0] day_threshold;
      logic [15:0] sample_interval_ms;
      logic [11:0] pulse_length_ms;
      logic        force_black_white;
      logic        sensor_present;
   } dnir_cfg_type;

   typedef struct packed {
      logic        op;
      logic [11:0] reading;
   } dnir_req_type;

   typedef struct packed {
      logic        drive_day;
      logic        drive_night;
      logic        night;
      logic [1:0]  effect_code;
      logic        want_readings;
      logic [11:0] last_average;
      logic        changed;
   } dnir_rsp_type;

endpackage

[sv/day_night_ir_cut_control_core.sv]
`timescale 1ns / 1ps
// Day/night IR-cut filter controller, top level: input stage, update engine, result stage.
// An input-stage beat is processed when it advances, which updates the engine state and loads the result register.
// Throughput: one beat per cycle while rsp_ready holds, set by the single-pass update between the two registers.
// While a finished result waits for rsp_ready, the input stage takes one more beat, then stalls.
// Reset (synchronous, active high) loads the register defaults and empties both stages.
// Depends on dnir_pkg, dnir_csr and dnir_engine.
module day_night_ir_cut_control_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dnir_pkg::dnir_req_type          req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dnir_pkg::dnir_rsp_type          rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dnir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dnir_pkg::CSR_DAT_W-1:0]  csr_data
);
   import dnir_pkg::*;

   dnir_cfg_type cfg;
   dnir_req_type in_ff;
   logic         in_valid_ff;
   dnir_rsp_type result;
   dnir_rsp_type rsp_ff;
   logic         out_valid_ff;
   logic         advance;

   // Register writes are always accepted, so csr_ready is tied high.
   assign csr_ready = 1'b1;

   dnir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Advance the held beat whenever the result stage is empty or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dnir_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Input stage: hold one beat until the engine takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_payload;
   end

   // Result stage: load on advance, drop once the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.drive_day && rsp_payload.drive_night))
      else $error("both bridge lines driven");

   a_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.night ? rsp_payload.effect_code == EFFECT_BW
                                       : rsp_payload.effect_code == EFFECT_COLOR))
      else $error("effect code disagrees with night status");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input stage refuses a beat");

   a_no_lost_beat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && !advance) |=> out_valid_ff)
      else $error("pending result dropped");
`endif

endmodule

[sv/dnir_csr.sv]
`timescale 1ns / 1ps
// Configuration register file of the IR-cut controller.
// Depends on dnir_pkg for the register index codes and the config struct.
module dnir_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [dnir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dnir_pkg::CSR_DAT_W-1:0]   csr_data,
   output dnir_pkg::dnir_cfg_type           cfg
);
   import dnir_pkg::*;

   dnir_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_threshold    <= 12'd1000;
         cfg_ff.day_threshold      <= 12'd1500;
         cfg_ff.sample_interval_ms <= 16'd5000;
         cfg_ff.pulse_length_ms    <= 12'd100;
         cfg_ff.force_black_white  <= 1'b0;
         cfg_ff.sensor_present     <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NIGHT_THR: cfg_ff.night_threshold    <= csr_data[11:0];
            CSR_DAY_THR:   cfg_ff.day_threshold      <= csr_data[11:0];
            CSR_INTERVAL:  cfg_ff.sample_interval_ms <= csr_data[15:0];
            CSR_PULSE_LEN: cfg_ff.pulse_length_ms    <= csr_data[11:0];
            CSR_FORCE_BW:  cfg_ff.force_black_white  <= csr_data[0];
            CSR_SENSOR:    cfg_ff.sensor_present     <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/dnir_engine.sv]
`timescale 1ns / 1ps
// Controller state and its single-pass update: sample interval, averaging, hysteresis, pulse, force/sensor overrides.
// Depends on dnir_pkg for the item, result and config structs.
module dnir_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  dnir_pkg::dnir_req_type  item,
   input  dnir_pkg::dnir_cfg_type  cfg,
   output dnir_pkg::dnir_rsp_type  result
);
   import dnir_pkg::*;

   logic [15:0]      elapsed_ff, elapsed_in;
   logic             collecting_ff, collecting_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             night_ff, night_in;
   logic             known_ff, known_in;
   logic [11:0]      pulse_ff, pulse_in;
   logic             pulse_night_ff, pulse_night_in;
   logic [11:0]      avg_ff, avg_in;

   always_comb begin
      logic             enabled;
      logic             changed;
      logic             want;
      logic             night_out;
      logic [SUM_W-1:0] sum_next;
      logic [CNT_W-1:0] taken_next;

      enabled        = !cfg.force_black_white && cfg.sensor_present;
      changed        = 1'b0;
      want           = night_ff;
      elapsed_in     = elapsed_ff;
      collecting_in  = collecting_ff;
      taken_in       = taken_ff;
      sum_in         = sum_ff;
      night_in       = night_ff;
      known_in       = known_ff;
      pulse_in       = pulse_ff;
      pulse_night_in = pulse_night_ff;
      avg_in         = avg_ff;
      sum_next       = sum_ff + SUM_W'(item.reading);
      taken_next     = taken_ff + CNT_W'(1);

      if (item.op == OP_TICK) begin
         if (pulse_ff != 12'd0) pulse_in = pulse_ff - 12'd1;
         if (elapsed_ff != ELAPSED_MAX) elapsed_in = elapsed_ff + 16'd1;
         if (enabled && !collecting_ff && elapsed_in >= cfg.sample_interval_ms) begin
            collecting_in = 1'b1;
            taken_in      = '0;
            sum_in        = '0;
            elapsed_in    = '0;
         end
      end else if (enabled && collecting_ff) begin
         sum_in   = sum_next;
         taken_in = taken_next;
         if (32'(taken_next) >= AVG_COUNT) begin
            // close the round and run the hysteresis decision
            avg_in        = 12'(sum_next / AVG_COUNT);
            collecting_in = 1'b0;
            taken_in      = '0;
            sum_in        = '0;
            priority if (avg_in < cfg.night_threshold) want = 1'b1;
            else if (avg_in > cfg.day_threshold)       want = 1'b0;
            else                                       want = night_ff;
            if (!known_ff || want != night_ff) begin
               changed        = 1'b1;
               night_in       = want;
               known_in       = 1'b1;
               pulse_night_in = want;
               pulse_in       = cfg.pulse_length_ms;
            end
         end
      end

      if (!enabled) begin
         collecting_in = 1'b0;
         taken_in      = '0;
         sum_in        = '0;
         pulse_in      = '0;
      end

      priority if (cfg.force_black_white) night_out = 1'b1;
      else if (!cfg.sensor_present)       night_out = 1'b0;
      else                                night_out = night_in;

      result.drive_day     = (pulse_in != 12'd0) && !pulse_night_in;
      result.drive_night   = (pulse_in != 12'd0) && pulse_night_in;
      result.night         = night_out;
      result.effect_code   = night_out ? EFFECT_BW : EFFECT_COLOR;
      result.want_readings = collecting_in;
      result.last_average  = avg_in;
      result.changed       = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff     <= ELAPSED_MAX;
         collecting_ff  <= 1'b0;
         taken_ff       <= '0;
         sum_ff         <= '0;
         night_ff       <= 1'b0;
         known_ff       <= 1'b0;
         pulse_ff       <= '0;
         pulse_night_ff <= 1'b0;
         avg_ff         <= '0;
      end else if (advance) begin
         elapsed_ff     <= elapsed_in;
         collecting_ff  <= collecting_in;
         taken_ff       <= taken_in;
         sum_ff         <= sum_in;
         night_ff       <= night_in;
         known_ff       <= known_in;
         pulse_ff       <= pulse_in;
         pulse_night_ff <= pulse_night_in;
         avg_ff         <= avg_in;
      end
   end

endmodule
